// ===== design/lrs16_pkg.sv =====
// Shared constants, command/status types and a divide helper for the 16 kHz resampler.
package lrs16_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int RATE_BITS     = 18;
    localparam int FRAC_BITS     = 15;
    localparam int STEP_BITS     = 4;
    localparam int REL_BITS      = 8;
    localparam int OUT_CNT_BITS  = 24;
    localparam int OUT_PROD_BITS = 41;
    localparam int RES_CNT_BITS  = 4;

    localparam int TARGET_RATE = 16000;
    localparam int DENOM       = 32000;
    localparam int RATE_MIN    = 4000;
    localparam int RATE_MAX    = 192000;
    localparam int RATE_RESET  = 48000;
    localparam int OUT_CAP     = 10000000;
    localparam int MAX_RESULTS = 8;
    localparam int MAX_QUOT    = 12;
    localparam int DIV_ODD     = 125;
    localparam int RECIP_ODD   = 33554;   // floor(2^22 / 125)

    typedef struct packed {
        logic [STEP_BITS-1:0] q;
        logic [FRAC_BITS-1:0] r;
    } divmod_t;

    typedef struct packed {
        logic load_in;
        logic start;
        logic hold_first;
        logic frame_accept;
        logic frame_sat;
        logic emit;
        logic result_load;
        logic pass_out;
        logic push;
        logic push_final;
        logic finish_clear;
        logic finish_rel_dec;
    } cmd_t;

    typedef struct packed {
        logic is_first;
        logic pass_mode;
        logic in_room;
        logic fin;
        logic cond_a;
        logic cond_b;
        logic out_free;
    } status_t;

    // Quotient and remainder by 32000 for values below 13 * 32000.
    function automatic divmod_t divmod_denom(input logic [RATE_BITS:0] v);
        logic [STEP_BITS-1:0] q;
        logic [RATE_BITS:0]   r;
        divmod_t              d;
        q = '0;
        for (int k = 1; k <= MAX_QUOT; k++)
        begin
            if (v >= (RATE_BITS+1)'(k * DENOM))
            begin
                q = STEP_BITS'(k);
            end
        end
        r   = v - (RATE_BITS+1)'(int'(q) * DENOM);
        d.q = q;
        d.r = r[FRAC_BITS-1:0];
        return d;
    endfunction

endpackage

// ===== design/lrs16_datapath.sv =====
// Datapath: stream state, position tracking, interpolation and divide-by-32000 stages.
module lrs16_datapath #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_valid,
    input  logic [lrs16_pkg::RATE_BITS-1:0]           cfg_data,
    input  logic signed [lrs16_pkg::SAMPLE_BITS-1:0]  sample_in,
    input  logic                                      is_final,
    input  logic                                      out_ready,
    input  lrs16_pkg::cmd_t                           cmd,
    output lrs16_pkg::status_t                        status,
    output logic signed [lrs16_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                                      final_out,
    output logic                                      out_valid
);

    localparam int SB       = lrs16_pkg::SAMPLE_BITS;
    localparam int RB       = lrs16_pkg::RATE_BITS;
    localparam int FB       = lrs16_pkg::FRAC_BITS;
    localparam int PB       = lrs16_pkg::REL_BITS;
    localparam int AIN_BITS = COUNT_BITS + 15;
    localparam int OPB      = lrs16_pkg::OUT_PROD_BITS;
    localparam int CMP_BITS = (AIN_BITS > OPB) ? AIN_BITS : OPB;
    localparam int ACC_BITS = 33;
    localparam int X_BITS   = 22;
    localparam int QE_BITS  = 16;

    localparam logic signed [PB-1:0] REL_MIN = {1'b1, {(PB-1){1'b0}}};

    // stream control state
    logic [RB-1:0]                         input_rate_reg;
    logic [RB-1:0]                         rate_reg;
    logic signed [SB-1:0]                  held_reg;
    logic [COUNT_BITS-1:0]                 inputs_seen_reg;
    logic [lrs16_pkg::OUT_CNT_BITS-1:0]    outputs_sent_reg;
    logic                                  out_valid_reg;

    // payload
    logic signed [SB-1:0]                  s_reg;
    logic                                  fin_reg;
    logic signed [PB-1:0]                  rel_reg;
    logic [FB-1:0]                         frac_reg;
    logic [lrs16_pkg::STEP_BITS-1:0]       step_whole_reg;
    logic [FB-1:0]                         step_frac_reg;
    logic [AIN_BITS-1:0]                   acc_in_reg;
    logic [OPB-1:0]                        out_prod_reg;
    logic signed [SB-1:0]                  cur_reg;
    logic signed [SB-1:0]                  before_reg;
    logic signed [31:0]                    prod_reg;
    logic signed [SB-1:0]                  v0_reg;
    logic [X_BITS-1:0]                     x_reg;
    logic                                  neg_reg;
    logic [QE_BITS-1:0]                    qe_reg;
    logic [SB-1:0]                         result_reg;
    logic signed [SB-1:0]                  sample_out_reg;
    logic                                  final_out_reg;

    logic [RB-1:0]                         eff_rate;
    lrs16_pkg::divmod_t                    start_pos;
    lrs16_pkg::divmod_t                    start_step;
    logic signed [PB-1:0]                  rel_p1;
    logic signed [PB-1:0]                  rel_dec;
    logic signed [SB-1:0]                  v0;
    logic signed [SB-1:0]                  v1;
    logic signed [SB:0]                    diff;
    logic signed [ACC_BITS-1:0]            prod_full;
    logic [FB:0]                           frac_sum;
    logic                                  carry;
    logic [FB:0]                           frac_wrap;
    logic signed [PB-1:0]                  rel_adv;
    logic signed [ACC_BITS-1:0]            v0_ext;
    logic signed [ACC_BITS-1:0]            acc;
    logic [ACC_BITS-1:0]                   mag;
    logic [X_BITS+QE_BITS-1:0]             qe_full;
    logic [X_BITS:0]                       qe_x;
    logic [X_BITS:0]                       rem;
    logic [QE_BITS:0]                      q_fix;
    logic [QE_BITS:0]                      q_signed;
    logic                                  out_load;
    logic                                  clear;
    logic                                  out_ok;

    always_comb
    begin
        if (input_rate_reg < RB'(lrs16_pkg::RATE_MIN))
        begin
            eff_rate = RB'(lrs16_pkg::RATE_MIN);
        end
        else if (input_rate_reg > RB'(lrs16_pkg::RATE_MAX))
        begin
            eff_rate = RB'(lrs16_pkg::RATE_MAX);
        end
        else
        begin
            eff_rate = input_rate_reg;
        end
    end

    assign start_pos  = lrs16_pkg::divmod_denom({1'b0, eff_rate} + (RB+1)'(lrs16_pkg::TARGET_RATE));
    assign start_step = lrs16_pkg::divmod_denom({eff_rate, 1'b0});

    assign rel_p1  = rel_reg + PB'(1);
    assign rel_dec = (rel_reg == REL_MIN) ? rel_reg : rel_reg - PB'(1);

    // neighbors of the output position relative to the current frame
    assign v0 = (rel_reg == '0) ? cur_reg : ((rel_reg == '1) ? before_reg : '0);
    assign v1 = (rel_p1 == '0)  ? cur_reg : ((rel_p1 == '1)  ? before_reg : '0);

    assign diff      = {v1[SB-1], v1} - {v0[SB-1], v0};
    assign prod_full = diff * $signed({1'b0, frac_reg});

    assign frac_sum  = {1'b0, frac_reg} + {1'b0, step_frac_reg};
    assign carry     = frac_sum >= (FB+1)'(lrs16_pkg::DENOM);
    assign frac_wrap = carry ? frac_sum - (FB+1)'(lrs16_pkg::DENOM) : frac_sum;
    assign rel_adv   = rel_reg
                     + $signed({{(PB-lrs16_pkg::STEP_BITS){1'b0}}, step_whole_reg})
                     + $signed({{(PB-1){1'b0}}, carry});

    // acc = v0*32000 + (v1-v0)*f
    assign v0_ext = {{(ACC_BITS-SB){v0_reg[SB-1]}}, v0_reg};
    assign acc    = (v0_ext <<< 15) - (v0_ext <<< 9) - (v0_ext <<< 8)
                  + {prod_reg[31], prod_reg};
    assign mag    = acc[ACC_BITS-1] ? ACC_BITS'(-acc) : ACC_BITS'(acc);

    // |acc| / 32000 = (|acc| >> 8) / 125, reciprocal estimate then one correction
    assign qe_full  = (X_BITS+QE_BITS)'(x_reg) * (X_BITS+QE_BITS)'(lrs16_pkg::RECIP_ODD);
    assign qe_x     = (X_BITS+1)'(qe_reg) * (X_BITS+1)'(lrs16_pkg::DIV_ODD);
    assign rem      = {1'b0, x_reg} - qe_x;
    assign q_fix    = {1'b0, qe_reg} + (QE_BITS+1)'(rem >= (X_BITS+1)'(lrs16_pkg::DIV_ODD));
    assign q_signed = neg_reg ? (QE_BITS+1)'(-q_fix) : q_fix;

    assign out_load = cmd.pass_out | cmd.push;
    assign clear    = cmd.finish_clear | (cmd.pass_out & fin_reg);
    assign out_ok   = outputs_sent_reg < lrs16_pkg::OUT_CNT_BITS'(lrs16_pkg::OUT_CAP);

    assign status.is_first  = (inputs_seen_reg == '0);
    assign status.pass_mode = (rate_reg == RB'(lrs16_pkg::TARGET_RATE));
    assign status.in_room   = ~&inputs_seen_reg;
    assign status.fin       = fin_reg;
    assign status.cond_a    = out_ok & rel_reg[PB-1];
    assign status.cond_b    = out_ok & ((outputs_sent_reg == '0)
                            | (CMP_BITS'(out_prod_reg) <= CMP_BITS'(acc_in_reg)));
    assign status.out_free  = ~out_valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_rate_reg   <= RB'(lrs16_pkg::RATE_RESET);
            rate_reg         <= '0;
            held_reg         <= '0;
            inputs_seen_reg  <= '0;
            outputs_sent_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                input_rate_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear)
            begin
                rate_reg         <= '0;
                held_reg         <= '0;
                inputs_seen_reg  <= '0;
                outputs_sent_reg <= '0;
            end
            else
            begin
                if (cmd.start)
                begin
                    rate_reg <= eff_rate;
                end
                if (cmd.hold_first || cmd.frame_accept)
                begin
                    held_reg        <= s_reg;
                    inputs_seen_reg <= inputs_seen_reg + COUNT_BITS'(1);
                end
                if (cmd.pass_out && status.in_room)
                begin
                    inputs_seen_reg <= inputs_seen_reg + COUNT_BITS'(1);
                end
                if (cmd.emit)
                begin
                    outputs_sent_reg <= outputs_sent_reg + lrs16_pkg::OUT_CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= mag[X_BITS+7:8];
        neg_reg <= acc[ACC_BITS-1];
        qe_reg  <= qe_full[X_BITS+QE_BITS-1:X_BITS];
        if (cmd.load_in)
        begin
            s_reg   <= sample_in;
            fin_reg <= is_final;
        end
        if (cmd.start)
        begin
            rel_reg        <= $signed({{(PB-lrs16_pkg::STEP_BITS){1'b0}}, start_pos.q}) - PB'(1);
            frac_reg       <= start_pos.r;
            step_whole_reg <= start_step.q;
            step_frac_reg  <= start_step.r;
            acc_in_reg     <= AIN_BITS'(eff_rate >> 1);
            out_prod_reg   <= OPB'(eff_rate);
        end
        if (cmd.hold_first)
        begin
            rel_reg    <= rel_dec;
            acc_in_reg <= acc_in_reg + AIN_BITS'(lrs16_pkg::TARGET_RATE);
        end
        if (cmd.frame_accept)
        begin
            cur_reg    <= s_reg;
            before_reg <= held_reg;
            acc_in_reg <= acc_in_reg + AIN_BITS'(lrs16_pkg::TARGET_RATE);
        end
        if (cmd.frame_sat)
        begin
            cur_reg    <= held_reg;
            before_reg <= '0;
            rel_reg    <= rel_p1;
        end
        if (cmd.emit)
        begin
            prod_reg     <= prod_full[31:0];
            v0_reg       <= v0;
            frac_reg     <= frac_wrap[FB-1:0];
            rel_reg      <= rel_adv;
            out_prod_reg <= out_prod_reg + OPB'(rate_reg);
        end
        if (cmd.finish_rel_dec)
        begin
            rel_reg <= rel_dec;
        end
        if (cmd.result_load)
        begin
            result_reg <= q_signed[SB-1:0];
        end
        if (cmd.pass_out)
        begin
            sample_out_reg <= s_reg;
            final_out_reg  <= fin_reg;
        end
        else if (cmd.push)
        begin
            sample_out_reg <= $signed(result_reg);
            final_out_reg  <= cmd.push_final;
        end
    end

    assign sample_out = sample_out_reg;
    assign final_out  = final_out_reg;
    assign out_valid  = out_valid_reg;

endmodule

// ===== design/lrs16_ctrl.sv =====
// Controller: sequences stream start, pass-through, and one interpolated output at a time.
module lrs16_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lrs16_pkg::status_t  status,
    output lrs16_pkg::cmd_t     cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_START = 9'b000000010,
        ST_CHECK = 9'b000000100,
        ST_PASS  = 9'b000001000,
        ST_EVAL  = 9'b000010000,
        ST_MUL   = 9'b000100000,
        ST_ACC   = 9'b001000000,
        ST_DIV1  = 9'b010000000,
        ST_DIV2  = 9'b100000000
    } state_t;

    localparam int NB = lrs16_pkg::RES_CNT_BITS;

    state_t          state_reg;
    state_t          state_next;
    logic [NB-1:0]   n_reg;
    logic [NB-1:0]   n_next;
    logic            phase_b_reg;
    logic            phase_b_next;
    logic            room;
    logic            more_a;
    logic            more_b;
    logic            another;
    logic            pending;

    assign room    = n_reg < NB'(lrs16_pkg::MAX_RESULTS);
    assign more_a  = ~phase_b_reg & status.cond_a & room;
    assign more_b  = status.fin & status.cond_b & room;
    assign another = more_a | more_b;
    assign pending = (n_reg != '0);

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        phase_b_next = phase_b_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = status.is_first ? ST_START : ST_CHECK;
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                n_next = '0;
                if (status.pass_mode || (status.is_first && status.fin))
                begin
                    state_next = ST_PASS;
                end
                else if (status.is_first)
                begin
                    cmd.hold_first = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (!status.in_room && !status.fin)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.in_room)
                begin
                    cmd.frame_accept = 1'b1;
                    phase_b_next     = 1'b0;
                    state_next       = ST_EVAL;
                end
                else
                begin
                    cmd.frame_sat = 1'b1;
                    phase_b_next  = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_PASS:
            begin
                if (status.out_free)
                begin
                    cmd.pass_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                if (!pending || status.out_free)
                begin
                    cmd.push       = pending;
                    cmd.push_final = ~another & status.fin;
                    if (another)
                    begin
                        if (!more_a)
                        begin
                            phase_b_next = 1'b1;
                        end
                        n_next     = n_reg + NB'(1);
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        cmd.finish_clear   = status.fin;
                        cmd.finish_rel_dec = ~status.fin;
                        state_next         = ST_IDLE;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.result_load = 1'b1;
                state_next      = ST_EVAL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            phase_b_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            phase_b_reg <= phase_b_next;
        end
    end

endmodule

// ===== design/linear_resampler_to_16khz.sv =====
// Top level: linear-interpolation sample-rate converter to 16 kHz.
//
// Channel  Handshake            Payload                    Direction
// -------  -------------------  -------------------------  ---------
// cfg      cfg_valid/cfg_ready  cfg_data[17:0] input_rate  in
// in       in_valid/in_ready    sample_in[15:0], is_final  in
// out      out_valid/out_ready  sample_out[15:0], final_out out
//
// Sequence: each interpolated output walks one multiply, one accumulate and a
//   two-step divide by 32000, all in a single shared datapath.
// Reset: rst_n clears the stream control state; input_rate returns to 48000. No clearing pass.
// Stalls: a finished output waits in the output register while the next input
//   transaction is taken; a further output waits in a pending register until the
//   output register is free. cfg_ready is always high.
module linear_resampler_to_16khz #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [lrs16_pkg::RATE_BITS-1:0]           cfg_data,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [lrs16_pkg::SAMPLE_BITS-1:0]  sample_in,
    input  logic                                      is_final,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [lrs16_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                                      final_out
);

    lrs16_pkg::cmd_t     cmd;
    lrs16_pkg::status_t  status;

    // The stream rate is latched at the first sample of each stream, so writes
    // are never held off.
    assign cfg_ready = 1'b1;

    // Sequencer: accepts a transaction, starts a stream, picks pass-through or
    // interpolation, and steps the shared datapath once per output.
    lrs16_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: stream counters, source position (whole part relative to the newest
    // sample, remainder over 32000), interpolation and the output register.
    lrs16_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .is_final   (is_final),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (status),
        .sample_out (sample_out),
        .final_out  (final_out),
        .out_valid  (out_valid)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the 16 kHz linear resampler: directed table, then random streams.
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_BITS  = lrs16_pkg::SAMPLE_BITS;
    localparam int RATE_BITS    = lrs16_pkg::RATE_BITS;
    localparam int FRAC_BITS    = lrs16_pkg::FRAC_BITS;
    localparam int OUT_CNT_BITS = lrs16_pkg::OUT_CNT_BITS;
    localparam int TARGET_RATE  = lrs16_pkg::TARGET_RATE;
    localparam int DENOM        = lrs16_pkg::DENOM;
    localparam int RATE_MIN     = lrs16_pkg::RATE_MIN;
    localparam int RATE_MAX     = lrs16_pkg::RATE_MAX;
    localparam int RATE_RESET   = lrs16_pkg::RATE_RESET;
    localparam int OUT_CAP      = lrs16_pkg::OUT_CAP;
    localparam int MAX_RESULTS  = lrs16_pkg::MAX_RESULTS;

    localparam int COUNT_BITS     = 24;
    localparam int DIR_ROWS       = 24;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 30;
    localparam int PRESSURE_PHASE = 8;    // receiver stalls long, sender keeps pushing
    localparam int PAUSE_PHASE    = 9;    // sender stops mid-phase until output drains
    localparam int HOLD_CYCLES    = 400;
    // Margin covers the worst-case transaction plus output stalls.
    localparam int SETTLE_CYCLES  = 60;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int MENU_SIZE      = 12;
    localparam int MAX_PRINTS     = 100;

    // How a directed row is checked: through the predictor, typed in by hand, or not at all.
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          is_last;
    } result_t;

    typedef struct packed {
        logic                          wr;       // write the rate before this row
        logic [RATE_BITS-1:0]          rate;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          fin;
        row_check_t                    chk;
        logic signed [SAMPLE_BITS-1:0] want_s;
        logic                          want_f;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [RATE_BITS-1:0]          cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          is_final;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          final_out;

    // Predictor copy of the block: config register plus per-stream state.
    logic [RATE_BITS-1:0]          rate_reg;
    logic [RATE_BITS-1:0]          pr_rate;      // rate latched at stream start
    logic signed [SAMPLE_BITS-1:0] pr_held;
    logic [COUNT_BITS-1:0]         pr_in_cnt;
    logic [OUT_CNT_BITS-1:0]       pr_out_cnt;
    logic signed [24:0]            pr_whole;
    logic [FRAC_BITS-1:0]          pr_frac;

    result_t step_res[$];       // outputs produced by the current input sample
    result_t expected_out[$];   // outputs still owed by the DUT, oldest first
    result_t head_exp;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int mismatches;
    int outputs_checked;
    int items_sent;
    int streams_done;
    int rate_writes;
    int cycle_count;

    row_t dir_tbl [DIR_ROWS] = '{
        // reset rate 48000: lone final sample passes, then a short stream
        '{1'b0, 18'd0,      16'sd100,    1'b1, CHK_ONE,   16'sd100,    1'b1},
        '{1'b0, 18'd0,      16'sd32767,  1'b0, CHK_NONE,  16'sd0,      1'b0},
        '{1'b0, 18'd0,      16'sh8000,   1'b0, CHK_MODEL, 16'sd0,      1'b0},
        '{1'b0, 18'd0,      16'sd12345,  1'b1, CHK_MODEL, 16'sd0,      1'b0},
        // 16 kHz: straight pass-through with final mark copied
        '{1'b1, 18'd16000,  16'sh8000,   1'b0, CHK_ONE,   16'sh8000,   1'b0},
        '{1'b0, 18'd0,      16'sd32767,  1'b0, CHK_ONE,   16'sd32767,  1'b0},
        '{1'b0, 18'd0,      16'sd0,      1'b1, CHK_ONE,   16'sd0,      1'b1},
        // lowest legal rate, four outputs per input
        '{1'b1, 18'd4000,   16'sd32767,  1'b0, CHK_NONE,  16'sd0,      1'b0},
        '{1'b0, 18'd0,      16'sh8000,   1'b0, CHK_MODEL, 16'sd0,      1'b0},
        '{1'b0, 18'd0,      -16'sd1,     1'b1, CHK_MODEL, 16'sd0,      1'b0},
        // highest legal rate, one output per twelve inputs
        '{1'b1, 18'd192000, 16'sd1,      1'b0, CHK_NONE,  16'sd0,      1'b0},
        '{1'b0, 18'd0,      16'sd32767,  1'b0, CHK_MODEL, 16'sd0,      1'b0},
        '{1'b0, 18'd0,      16'sh8000,   1'b0, CHK_MODEL, 16'sd0,      1'b0},
        '{1'b0, 18'd0,      -16'sd2,     1'b0, CHK_MODEL, 16'sd0,      1'b0},
        '{1'b0, 18'd0,      16'sd7,      1'b1, CHK_MODEL, 16'sd0,      1'b0},
        // rate 0 saturates up to 4000
        '{1'b1, 18'd0,      16'sd32767,  1'b1, CHK_ONE,   16'sd32767,  1'b1},
        '{1'b0, 18'd0,      16'sh8000,   1'b0, CHK_NONE,  16'sd0,      1'b0},
        '{1'b0, 18'd0,      16'sd32767,  1'b1, CHK_MODEL, 16'sd0,      1'b0},
        // all-ones rate saturates down to 192000
        '{1'b1, 18'h3FFFF,  16'sh8000,   1'b0, CHK_NONE,  16'sd0,      1'b0},
        '{1'b0, 18'd0,      16'sd100,    1'b0, CHK_MODEL, 16'sd0,      1'b0},
        '{1'b0, 18'd0,      -16'sd100,   1'b1, CHK_MODEL, 16'sd0,      1'b0},
        // non-integer ratio
        '{1'b1, 18'd44100,  16'sd1000,   1'b0, CHK_NONE,  16'sd0,      1'b0},
        '{1'b0, 18'd0,      -16'sd1000,  1'b0, CHK_MODEL, 16'sd0,      1'b0},
        '{1'b0, 18'd0,      16'sd5,      1'b1, CHK_MODEL, 16'sd0,      1'b0}
    };

    logic [RATE_BITS-1:0] rate_menu [MENU_SIZE] = '{
        18'd4000, 18'd192000, 18'd16000, 18'd44100, 18'd8000, 18'd3999,
        18'd96000, 18'h3FFFF, 18'd11025, 18'd22050, 18'd0, 18'd192001
    };

    linear_resampler_to_16khz #(
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .is_final   (is_final),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .final_out  (final_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void clear_stream();
        pr_held    = '0;
        pr_in_cnt  = '0;
        pr_out_cnt = '0;
        pr_whole   = '0;
        pr_frac    = '0;
        pr_rate    = '0;
    endfunction

    // Source sample i, given the newest index and the two samples on hand.
    function automatic longint src_at(longint i, longint newest, longint cur, longint prev);
        if (i == newest && i >= 0)
            return cur;
        if (i == newest - 1 && i >= 0)
            return prev;
        return 0;
    endfunction

    // One interpolated output at the current position, then step by 2*R/32000.
    function automatic void emit_interp(longint newest, longint cur, longint prev);
        longint  whole;
        longint  frac;
        longint  acc;
        longint  step;
        result_t r;
        whole = longint'(pr_whole);
        frac  = longint'(pr_frac);
        acc   = src_at(whole, newest, cur, prev) * (DENOM - frac)
              + src_at(whole + 1, newest, cur, prev) * frac;
        r.sample  = SAMPLE_BITS'(acc / DENOM);   // truncates toward zero
        r.is_last = 1'b0;
        step_res.push_back(r);
        step  = 2 * longint'(pr_rate);
        whole = whole + step / DENOM;
        frac  = frac + step % DENOM;
        if (frac >= DENOM)
        begin
            frac  = frac - DENOM;
            whole = whole + 1;
        end
        pr_whole   = 25'(whole);
        pr_frac    = FRAC_BITS'(frac);
        pr_out_cnt = pr_out_cnt + 1'b1;
    endfunction

    // Outputs caused by one accepted input sample, left in step_res.
    function automatic void resample_step(logic signed [SAMPLE_BITS-1:0] s, logic fin);
        longint  max_in;
        longint  rate_eff;
        longint  num;
        longint  whole;
        longint  newest;
        longint  cur;
        longint  prev;
        longint  total;
        bit      room;
        result_t r;
        step_res.delete();
        max_in = (longint'(1) << COUNT_BITS) - 1;
        room   = longint'(pr_in_cnt) < max_in;

        // Stream start: latch the saturated rate, place output zero.
        if (pr_in_cnt == 0)
        begin
            rate_eff = longint'(rate_reg);
            if (rate_eff < RATE_MIN)
                rate_eff = RATE_MIN;
            if (rate_eff > RATE_MAX)
                rate_eff = RATE_MAX;
            pr_rate = RATE_BITS'(rate_eff);
            num     = rate_eff - TARGET_RATE;
            if (num < 0)
                whole = -((-num + DENOM - 1) / DENOM);
            else
                whole = num / DENOM;
            pr_whole = 25'(whole);
            pr_frac  = FRAC_BITS'(num - whole * DENOM);
        end

        // Pass-through: 16 kHz stream, or a lone final sample.
        if (pr_rate == TARGET_RATE || (pr_in_cnt == 0 && fin))
        begin
            r.sample  = s;
            r.is_last = fin;
            step_res.push_back(r);
            if (fin)
                clear_stream();
            else if (room)
                pr_in_cnt = pr_in_cnt + 1'b1;
            return;
        end

        if (pr_in_cnt == 0)
        begin
            pr_held   = s;
            pr_in_cnt = 1;
            return;
        end
        if (!room && !fin)
            return;

        if (room)
        begin
            newest = longint'(pr_in_cnt);
            cur    = longint'(s);
            prev   = longint'(pr_held);
            while (step_res.size() < MAX_RESULTS && pr_out_cnt < OUT_CAP
                   && longint'(pr_whole) <= newest - 1)
                emit_interp(newest, cur, prev);
            pr_held   = s;
            pr_in_cnt = pr_in_cnt + 1'b1;
        end
        else
        begin
            // counter full: the final sample is dropped, held one is the last
            newest = longint'(pr_in_cnt) - 1;
            cur    = longint'(pr_held);
            prev   = 0;
        end

        // Tail: run out to round(n*16000/R), clamped to [1, cap].
        if (fin)
        begin
            total = (longint'(pr_in_cnt) * TARGET_RATE + longint'(pr_rate) / 2)
                  / longint'(pr_rate);
            if (total < 1)
                total = 1;
            if (total > OUT_CAP)
                total = OUT_CAP;
            while (step_res.size() < MAX_RESULTS && longint'(pr_out_cnt) < total)
                emit_interp(newest, cur, prev);
            if (step_res.size() > 0)
                step_res[step_res.size()-1].is_last = 1'b1;
            clear_stream();
        end
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one sample; idles per cycle first. Valid stays up until the transaction.
    task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic f,
                                input row_check_t chk,
                                input logic signed [SAMPLE_BITS-1:0] want_s,
                                input logic want_f);
        result_t typed;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        is_final  <= f;
        do @(posedge clk); while (!in_ready);
        resample_step(s, f);
        case (chk)
            CHK_MODEL:
                foreach (step_res[i])
                    expected_out.push_back(step_res[i]);
            CHK_ONE:
            begin
                typed.sample  = want_s;
                typed.is_last = want_f;
                expected_out.push_back(typed);
            end
            default: ;
        endcase
        items_sent++;
        if (f)
            streams_done++;
    endtask

    // Sender rests until every owed output is out, plus settle time for
    // samples that produce nothing but keep the datapath busy.
    task automatic drain_idle();
        in_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_reg = v;
        rate_writes++;
    endtask

    // ---------------------------------------------------------------
    // Output side: check each transaction, then pick next ready.
    // Values read just after the edge are the ones sampled at it.
    // ---------------------------------------------------------------
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_out.size() == 0)
                    flag_mismatch("output with nothing expected", int'(sample_out), 0);
                else
                begin
                    head_exp = expected_out.pop_front();
                    if (sample_out !== head_exp.sample)
                        flag_mismatch("sample_out", int'(sample_out), int'(head_exp.sample));
                    if (final_out !== head_exp.is_last)
                        flag_mismatch("final_out", int'(final_out), int'(head_exp.is_last));
                    outputs_checked++;
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d outputs still owed",
                 cycle_count, expected_out.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int                            phase;
        int                            k;
        int                            stream_left;
        int                            menu_ofs;
        int                            pick;
        logic signed [SAMPLE_BITS-1:0] s;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        sample_in <= '0;
        is_final  <= 1'b0;
        send_idle_pct   = 23;
        recv_idle_pct   = 78;
        hold_cycles     = 0;
        mismatches      = 0;
        outputs_checked = 0;
        items_sent      = 0;
        streams_done    = 0;
        rate_writes     = 0;
        rate_reg        = RATE_BITS'(RATE_RESET);
        clear_stream();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; first rows run at the reset rate.
        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_tbl[k].wr)
            begin
                drain_idle();
                write_rate(dir_tbl[k].rate);
            end
            offer_sample(dir_tbl[k].sample, dir_tbl[k].fin, dir_tbl[k].chk,
                         dir_tbl[k].want_s, dir_tbl[k].want_f);
        end

        // Random streams. Streams run across phase boundaries, so a rate
        // written mid-stream must only take hold on the next stream.
        stream_left = 0;
        menu_ofs    = $urandom_range(MENU_SIZE - 1);
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 4)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 78;
            end
            else if (phase < 8)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain_idle();
            if (phase == PRESSURE_PHASE)
            begin
                // 4 outputs per sample fills the output stage fast
                write_rate(RATE_BITS'(RATE_MIN));
                hold_cycles = HOLD_CYCLES;
            end
            else
                write_rate(rate_menu[(phase + menu_ofs) % MENU_SIZE]);

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == PAUSE_PHASE && k == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (expected_out.size() != 0);
                end
                if (stream_left == 0)
                begin
                    pick = $urandom_range(99);
                    if (pick < 15)
                        stream_left = 1;
                    else if (pick < 85)
                        stream_left = $urandom_range(12, 2);
                    else
                        stream_left = $urandom_range(40, 13);
                end
                pick = $urandom_range(99);
                if (pick < 3)
                    s = 16'sd32767;
                else if (pick < 6)
                    s = 16'sh8000;
                else if (pick < 8)
                    s = 16'sd0;
                else if (pick < 10)
                    s = -16'sd1;
                else
                    s = SAMPLE_BITS'($urandom);
                offer_sample(s, (stream_left == 1), CHK_MODEL, 16'sd0, 1'b0);
                stream_left--;
            end
        end

        // Close any open stream so its tail gets checked too.
        if (pr_in_cnt != 0)
            offer_sample(SAMPLE_BITS'($urandom), 1'b1, CHK_MODEL, 16'sd0, 1'b0);
        in_valid <= 1'b0;

        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d input samples in %0d streams over %0d rate writes,",
                 items_sent, streams_done, rate_writes);
        $display("%0d output samples compared, %0d mismatches.",
                 outputs_checked, mismatches);
        if (mismatches == 0 && expected_out.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
